>>> hdl/scd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// Shared constants, types and lookup functions for the scan code decoder.
// ----------------------------------------------------------------------------
package scd_pkg;

  // default size of the key-down map
  localparam int NUM_KEYS_DEF = 86;

  // widths of the stream beats
  localparam int CODE_W     = 8;
  localparam int MAKE_W     = 7;
  localparam int CHAR_W     = 7;
  localparam int SLOT_RAW_W = 7;
  localparam int OUT_DATA_W = 16;

  // map slots of the keys that steer the decoder
  localparam logic [SLOT_RAW_W-1:0] SLOT_ESC    = 7'd0;
  localparam logic [SLOT_RAW_W-1:0] SLOT_CTRL   = 7'd27;
  localparam logic [SLOT_RAW_W-1:0] SLOT_LSHIFT = 7'd40;
  localparam logic [SLOT_RAW_W-1:0] SLOT_RSHIFT = 7'd52;

  // make codes with special meaning
  localparam logic [MAKE_W-1:0] MAKE_BACKSPACE = 7'h0E;
  localparam logic [MAKE_W-1:0] MAKE_HOLE      = 7'h54;
  localparam logic [MAKE_W-1:0] MAKE_LAST      = 7'h58;

  // character answered when the escape combo is held
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  // modifier view handed from the key map to the translator
  typedef struct packed {
    logic combo;
    logic shift;
  } key_status_t;

  // slot lookup result
  typedef struct packed {
    logic                  valid;
    logic [SLOT_RAW_W-1:0] slot;
  } slot_t;

  // key known to the decoder (backspace included)
  function automatic logic code_known(input logic [MAKE_W-1:0] make);
    code_known = (make != '0) && (make <= MAKE_LAST) && (make != MAKE_HOLE);
  endfunction

  // map slot of a make code; backspace and the hole have none
  function automatic slot_t slot_of(input logic [MAKE_W-1:0] make);
    slot_t s;
    s.valid = 1'b0;
    s.slot  = '0;
    case (make) inside
      [7'h01:7'h0D]: begin
        s.valid = 1'b1;
        s.slot  = make - 7'd1;
      end
      [7'h0F:7'h53]: begin
        s.valid = 1'b1;
        s.slot  = make - 7'd2;
      end
      [7'h55:7'h58]: begin
        s.valid = 1'b1;
        s.slot  = make - 7'd3;
      end
      default: begin
        s.valid = 1'b0;
        s.slot  = '0;
      end
    endcase
    slot_of = s;
  endfunction

  // unshifted character of a key
  function automatic logic [CHAR_W-1:0] plain_char(input logic [MAKE_W-1:0] make);
    case (make)
      7'h02: plain_char = 7'h31;
      7'h03: plain_char = 7'h32;
      7'h04: plain_char = 7'h33;
      7'h05: plain_char = 7'h34;
      7'h06: plain_char = 7'h35;
      7'h07: plain_char = 7'h36;
      7'h08: plain_char = 7'h37;
      7'h09: plain_char = 7'h38;
      7'h0A: plain_char = 7'h39;
      7'h0B: plain_char = 7'h30;
      7'h0C: plain_char = 7'h2D;
      7'h0D: plain_char = 7'h3D;
      7'h0F: plain_char = 7'h09;
      7'h10: plain_char = 7'h71;
      7'h11: plain_char = 7'h77;
      7'h12: plain_char = 7'h65;
      7'h13: plain_char = 7'h72;
      7'h14: plain_char = 7'h74;
      7'h15: plain_char = 7'h79;
      7'h16: plain_char = 7'h75;
      7'h17: plain_char = 7'h69;
      7'h18: plain_char = 7'h6F;
      7'h19: plain_char = 7'h70;
      7'h1A: plain_char = 7'h5B;
      7'h1B: plain_char = 7'h5D;
      7'h1C: plain_char = 7'h0A;
      7'h1E: plain_char = 7'h61;
      7'h1F: plain_char = 7'h73;
      7'h20: plain_char = 7'h64;
      7'h21: plain_char = 7'h66;
      7'h22: plain_char = 7'h67;
      7'h23: plain_char = 7'h68;
      7'h24: plain_char = 7'h6A;
      7'h25: plain_char = 7'h6B;
      7'h26: plain_char = 7'h6C;
      7'h27: plain_char = 7'h3B;
      7'h28: plain_char = 7'h27;
      7'h29: plain_char = 7'h60;
      7'h2B: plain_char = 7'h5C;
      7'h2C: plain_char = 7'h7A;
      7'h2D: plain_char = 7'h78;
      7'h2E: plain_char = 7'h63;
      7'h2F: plain_char = 7'h76;
      7'h30: plain_char = 7'h62;
      7'h31: plain_char = 7'h6E;
      7'h32: plain_char = 7'h6D;
      7'h33: plain_char = 7'h2C;
      7'h34: plain_char = 7'h2E;
      7'h35: plain_char = 7'h2F;
      7'h39: plain_char = 7'h20;
      7'h47: plain_char = 7'h37;
      7'h48: plain_char = 7'h38;
      7'h49: plain_char = 7'h39;
      7'h4A: plain_char = 7'h2D;
      7'h4B: plain_char = 7'h34;
      7'h4C: plain_char = 7'h35;
      7'h4D: plain_char = 7'h36;
      7'h4F: plain_char = 7'h31;
      7'h50: plain_char = 7'h32;
      7'h51: plain_char = 7'h33;
      7'h52: plain_char = 7'h30;
      7'h53: plain_char = 7'h2E;
      default: plain_char = 7'h00;
    endcase
  endfunction

  // shifted character of a key; keypad follows the main row pairing
  function automatic logic [CHAR_W-1:0] shifted_char(input logic [MAKE_W-1:0] make);
    case (make)
      7'h02: shifted_char = 7'h21;
      7'h03: shifted_char = 7'h40;
      7'h04: shifted_char = 7'h23;
      7'h05: shifted_char = 7'h24;
      7'h06: shifted_char = 7'h25;
      7'h07: shifted_char = 7'h5E;
      7'h08: shifted_char = 7'h26;
      7'h09: shifted_char = 7'h2A;
      7'h0A: shifted_char = 7'h28;
      7'h0B: shifted_char = 7'h29;
      7'h0C: shifted_char = 7'h5F;
      7'h0D: shifted_char = 7'h2B;
      7'h0F: shifted_char = 7'h09;
      7'h10: shifted_char = 7'h51;
      7'h11: shifted_char = 7'h57;
      7'h12: shifted_char = 7'h45;
      7'h13: shifted_char = 7'h52;
      7'h14: shifted_char = 7'h54;
      7'h15: shifted_char = 7'h59;
      7'h16: shifted_char = 7'h55;
      7'h17: shifted_char = 7'h49;
      7'h18: shifted_char = 7'h4F;
      7'h19: shifted_char = 7'h50;
      7'h1A: shifted_char = 7'h7B;
      7'h1B: shifted_char = 7'h7D;
      7'h1C: shifted_char = 7'h0A;
      7'h1E: shifted_char = 7'h41;
      7'h1F: shifted_char = 7'h53;
      7'h20: shifted_char = 7'h44;
      7'h21: shifted_char = 7'h46;
      7'h22: shifted_char = 7'h47;
      7'h23: shifted_char = 7'h48;
      7'h24: shifted_char = 7'h4A;
      7'h25: shifted_char = 7'h4B;
      7'h26: shifted_char = 7'h4C;
      7'h27: shifted_char = 7'h3A;
      7'h28: shifted_char = 7'h22;
      7'h29: shifted_char = 7'h7E;
      7'h2B: shifted_char = 7'h7C;
      7'h2C: shifted_char = 7'h5A;
      7'h2D: shifted_char = 7'h58;
      7'h2E: shifted_char = 7'h43;
      7'h2F: shifted_char = 7'h56;
      7'h30: shifted_char = 7'h42;
      7'h31: shifted_char = 7'h4E;
      7'h32: shifted_char = 7'h4D;
      7'h33: shifted_char = 7'h3C;
      7'h34: shifted_char = 7'h3E;
      7'h35: shifted_char = 7'h3F;
      7'h39: shifted_char = 7'h20;
      7'h47: shifted_char = 7'h26;
      7'h48: shifted_char = 7'h2A;
      7'h49: shifted_char = 7'h28;
      7'h4A: shifted_char = 7'h5F;
      7'h4B: shifted_char = 7'h24;
      7'h4C: shifted_char = 7'h25;
      7'h4D: shifted_char = 7'h5E;
      7'h4F: shifted_char = 7'h21;
      7'h50: shifted_char = 7'h40;
      7'h51: shifted_char = 7'h23;
      7'h52: shifted_char = 7'h29;
      7'h53: shifted_char = 7'h3E;
      default: shifted_char = 7'h00;
    endcase
  endfunction

endpackage

>>> hdl/scd_key_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_key_map
// Key-down map and shift flag; reports the modifier view after the update
// made by the code in the input register.
// ----------------------------------------------------------------------------
module scd_key_map
  import scd_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CODE_W-1:0] code,      // code held in the input register
  input  logic              commit,    // code moves on this cycle
  output key_status_t       status
);

  localparam int SLOT_W = $clog2(NUM_KEYS);

  logic [NUM_KEYS-1:0] key_down_map;
  logic                shift_active;
  logic                shift_active_next;

  logic [MAKE_W-1:0]   make;
  logic                release_bit;
  slot_t               slot_info;
  logic                map_write;
  logic [SLOT_W-1:0]   slot_idx;
  logic                esc_down;
  logic                ctrl_down;
  logic                lshift_down;
  logic                rshift_down;
  logic                any_shift;
  logic                combo;

  // decode the held code
  always_comb begin
    make        = code[MAKE_W-1:0];
    release_bit = code[CODE_W-1];
    slot_info   = slot_of(make);
    map_write   = code_known(make) && slot_info.valid;
    slot_idx    = SLOT_W'(slot_info.slot);
  end

  // modifier bits as they stand after this code's update
  always_comb begin
    esc_down    = (map_write && slot_info.slot == SLOT_ESC) ?
                  !release_bit : key_down_map[SLOT_ESC];
    ctrl_down   = (map_write && slot_info.slot == SLOT_CTRL) ?
                  !release_bit : key_down_map[SLOT_CTRL];
    lshift_down = (map_write && slot_info.slot == SLOT_LSHIFT) ?
                  !release_bit : key_down_map[SLOT_LSHIFT];
    rshift_down = (map_write && slot_info.slot == SLOT_RSHIFT) ?
                  !release_bit : key_down_map[SLOT_RSHIFT];
    any_shift   = lshift_down || rshift_down;
    combo       = ctrl_down && any_shift && esc_down;
    // shift is left alone while the combo is held
    shift_active_next = combo ? shift_active : any_shift;
    status.combo = combo;
    status.shift = shift_active_next;
  end

  // map and shift state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_down_map <= '0;
      shift_active <= 1'b0;
    end else if (commit) begin
      if (map_write) begin
        key_down_map[slot_idx] <= !release_bit;
      end
      shift_active <= shift_active_next;
    end
  end

endmodule

>>> hdl/scd_xlate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_xlate
// Character lookup and the result register on the master side.
// ----------------------------------------------------------------------------
module scd_xlate
  import scd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CODE_W-1:0]     code,
  input  key_status_t           status,
  input  logic                  load,      // take a new result this cycle
  output logic                  free,      // result register can take a beat
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // ascii_char[6:0], key_pressed[7], combo_hit[8]
);

  logic [MAKE_W-1:0] make;
  logic [CHAR_W-1:0] ascii_char;
  logic              key_pressed;

  // table lookup with shift applied; space while the combo is held
  always_comb begin
    make        = code[MAKE_W-1:0];
    key_pressed = code_known(make) && !code[CODE_W-1];
    if (status.combo) begin
      ascii_char = CHAR_SPACE;
    end else if (status.shift) begin
      ascii_char = shifted_char(make);
    end else begin
      ascii_char = plain_char(make);
    end
  end

  assign free = !m_tvalid || m_tready;

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {(OUT_DATA_W - CHAR_W - 2)'(0), status.combo, key_pressed, ascii_char};
    end
  end

endmodule

>>> hdl/scan_code_to_ascii_decoder.sv
`timescale 1ns / 1ps
// Path: an accepted input beat is held in the input register, then moves to the result register when it has room.
// Throughput: one scan code per cycle; the input register and the result
// register pass beats every cycle while the output side keeps taking them.
// Reset (synchronous): clears the key-down map, the shift flag and both
// valid flags; no beat is held after reset.
// ----------------------------------------------------------------------------
// scan_code_to_ascii_decoder
// Scan code set 1 bytes in, ASCII characters with key and combo flags out.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_decoder
  import scd_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CODE_W-1:0]     s_tdata,   // scan_code[7:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // ascii_char[6:0], key_pressed[7], combo_hit[8]
);

  logic              in_valid;
  logic [CODE_W-1:0] in_code;
  logic              free;
  logic              advance;
  key_status_t       status;

  // input register moves on when the result register has room
  assign advance  = in_valid && free;
  assign s_tready = !in_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_code <= s_tdata;
    end
  end

  // key map and modifiers
  scd_key_map #(
    .NUM_KEYS (NUM_KEYS)
  ) u_key_map (
    .clk    (clk),
    .rst    (rst),
    .code   (in_code),
    .commit (advance),
    .status (status)
  );

  // translation and result beat
  scd_xlate u_xlate (
    .clk      (clk),
    .rst      (rst),
    .code     (in_code),
    .status   (status),
    .load     (advance),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scan code decoder. Scan code bytes go in on the
// input stream and are tracked by a key-map predictor inside the bench. Each
// result beat is compared field by field with the oldest predicted character.
// Random gaps on both sides, one long output hold-off, and typed key
// sequences with shift and the control-shift-escape combo.
// ----------------------------------------------------------------------------
module tb;
  import scd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;

  // make codes used to build key sequences
  localparam logic [7:0] MK_ESC    = 8'h01;
  localparam logic [7:0] MK_EQUALS = 8'h0D;
  localparam logic [7:0] MK_CTRL   = 8'h1D;
  localparam logic [7:0] MK_LSHIFT = 8'h2A;
  localparam logic [7:0] MK_RSHIFT = 8'h36;
  localparam logic [7:0] MK_KP7    = 8'h47;
  localparam logic [7:0] MK_KPDOT  = 8'h53;
  localparam logic [7:0] BREAK_BIT = 8'h80;

  typedef struct {
    logic [CHAR_W-1:0] ascii;
    logic              pressed;
    logic              combo;
  } key_result_t;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CODE_W-1:0]     s_tdata  = '0;   // scan_code[7:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // ascii_char[6:0], key_pressed[7], combo_hit[8]

  // predictor state
  bit          key_down [NUM_KEYS_DEF];
  bit          shift_on;
  byte         plain_lut [128];
  byte         shift_lut [128];
  key_result_t pending_chars [$];

  int errors     = 0;
  int beats_sent = 0;
  int cycle_cnt  = 0;
  bit idle_on    = 1'b1;
  bit hold_req   = 1'b0;

  scan_code_to_ascii_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("scan_code_to_ascii_decoder test failed");
    $finish;
  end

  // fill a run of consecutive keys in the character tables
  function automatic void load_keys(input int first, input string lo, input string hi);
    for (int i = 0; i < lo.len(); i++) begin
      plain_lut[first + i] = lo[i];
      shift_lut[first + i] = hi[i];
    end
  endfunction

  // update the key map with one code and work out the character beat
  function automatic key_result_t decode_code(input logic [7:0] code);
    logic [MAKE_W-1:0] make;
    bit                brk;
    bit                known;
    bit                any_shift;
    int                slot;
    key_result_t       r;
    make  = code[6:0];
    brk   = code[7];
    known = (make != 0) && (make <= MAKE_LAST) && (make != MAKE_HOLE);
    if (make <= 7'h0D) slot = int'(make) - 1;
    else if (make <= 7'h53) slot = int'(make) - 2;
    else slot = int'(make) - 3;
    // backspace has no map bit
    if (known && make != MAKE_BACKSPACE) key_down[slot] = !brk;
    any_shift = key_down[SLOT_LSHIFT] | key_down[SLOT_RSHIFT];
    r.pressed = known && !brk;
    if (key_down[SLOT_CTRL] && any_shift && key_down[SLOT_ESC]) begin
      r.ascii = CHAR_SPACE;
      r.combo = 1'b1;
    end else begin
      shift_on = any_shift;
      r.ascii  = shift_on ? shift_lut[make][6:0] : plain_lut[make][6:0];
      r.combo  = 1'b0;
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_key();
    logic [7:0] m;
    do m = 8'($urandom_range(1, MAKE_LAST)); while (m == 8'(MAKE_HOLE));
    return m;
  endfunction

  // predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    key_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) pending_chars.push_back(decode_code(s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_chars.size() == 0) begin
          $error("result beat with nothing expected: m_tdata %h", m_tdata);
          errors++;
        end else begin
          want = pending_chars.pop_front();
          if (m_tdata[6:0] !== want.ascii) begin
            $error("ascii_char expected %h actual %h", want.ascii, m_tdata[6:0]);
            errors++;
          end
          if (m_tdata[7] !== want.pressed) begin
            $error("key_pressed expected %b actual %b", want.pressed, m_tdata[7]);
            errors++;
          end
          if (m_tdata[8] !== want.combo) begin
            $error("combo_hit expected %b actual %b", want.combo, m_tdata[8]);
            errors++;
          end
          if (m_tdata[15:9] !== '0) begin
            $error("pad expected %h actual %h", 7'h00, m_tdata[15:9]);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int d;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        d = pick_gap();
        if (d > 0) begin
          m_tready <= 1'b0;
          repeat (d) @(posedge clk);
        end
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one scan code and wait for the beat to be taken
  task automatic send_code(input logic [7:0] code);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tap_key(input logic [7:0] make);
    send_code(make);
    send_code(make | BREAK_BIT);
  endtask

  // field extremes, unknown codes, backspace, keypad shift, combo
  task automatic test_directed();
    logic [7:0] codes [$];
    codes = {8'h00, 8'hFF, 8'h7F, 8'h80, MK_ESC, MK_ESC | BREAK_BIT,
             MK_EQUALS, 8'(MAKE_BACKSPACE), 8'h8E, MK_EQUALS | BREAK_BIT,
             8'(MAKE_HOLE), 8'hD4, 8'h59, 8'h3B, 8'(MAKE_LAST),
             MK_LSHIFT, MK_KP7, MK_KPDOT, MK_LSHIFT | BREAK_BIT,
             MK_RSHIFT, 8'h10, MK_RSHIFT | BREAK_BIT,
             MK_CTRL, MK_LSHIFT, MK_ESC};
    foreach (codes[i]) send_code(codes[i]);
    // combo held: known key, unknown code, then let go
    send_code(8'h1E);
    send_code(8'h00);
    send_code(MK_ESC | BREAK_BIT);
    send_code(MK_LSHIFT | BREAK_BIT);
    send_code(MK_CTRL | BREAK_BIT);
  endtask

  // well-formed typing with shift and combo runs, some noise
  task automatic test_typing(input int n_beats);
    logic [7:0] mods [3];
    logic [7:0] sh;
    logic [7:0] t;
    int         stop;
    int         r;
    int         j;
    stop = beats_sent + n_beats;
    while (beats_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        tap_key(any_key());
      end else if (r < 75) begin
        sh = $urandom_range(0, 1) ? MK_LSHIFT : MK_RSHIFT;
        send_code(sh);
        repeat ($urandom_range(1, 5)) tap_key(any_key());
        send_code(sh | BREAK_BIT);
      end else if (r < 88) begin
        mods = '{MK_CTRL, $urandom_range(0, 1) ? MK_LSHIFT : MK_RSHIFT, MK_ESC};
        for (int i = 2; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = mods[i]; mods[i] = mods[j]; mods[j] = t;
        end
        foreach (mods[i]) send_code(mods[i]);
        repeat ($urandom_range(0, 2)) tap_key(any_key());
        for (int i = 2; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = mods[i]; mods[i] = mods[j]; mods[j] = t;
        end
        foreach (mods[i]) send_code(mods[i] | BREAK_BIT);
      end else begin
        send_code(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // raw random bytes
  task automatic test_random_bytes(input int n_beats);
    repeat (n_beats) send_code(8'($urandom_range(0, 255)));
  endtask

  // output held off while codes keep coming, so the input side stalls
  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (20) tap_key(any_key());
    idle_on = 1'b1;
  endtask

  // back-to-back beats with no gaps on either side
  task automatic test_full_rate(input int n_beats);
    idle_on = 1'b0;
    test_typing(n_beats);
    idle_on = 1'b1;
  endtask

  initial begin
    load_keys('h02, "1234567890-=", "!@#$%^&*()_+");
    load_keys('h0F, "\tqwertyuiop[]\n", "\tQWERTYUIOP{}\n");
    load_keys('h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
    // backtick key
    plain_lut[8'h29] = 8'h60;
    shift_lut[8'h29] = 8'h7E;
    load_keys('h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
    load_keys('h39, " ", " ");
    load_keys('h47, "789-456", "&*(_$%^");
    load_keys('h4F, "1230.", "!@#)>");

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_typing(280);
    test_backpressure();
    test_random_bytes(130);
    test_full_rate(60);
    s_tvalid <= 1'b0;

    // drain outstanding results
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("scan_code_to_ascii_decoder test passed");
    end else begin
      $display("scan_code_to_ascii_decoder test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/scd_pkg.sv
hdl/scd_key_map.sv
hdl/scd_xlate.sv
hdl/scan_code_to_ascii_decoder.sv
verif/tb.sv
